// ----- hw/rtl/djbhp_pkg.sv -----
package djbhp_pkg;

    localparam int HASH_W      = 64;
    localparam int CHAR_W      = 8;
    localparam int PART_W      = 16;
    localparam int DIV_STEPS   = HASH_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam logic [CHAR_W-1:0] KEY_END   = 8'd0;
    localparam logic [PART_W-1:0] PART_MIN  = 16'd1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_char;
        logic start_div;
        logic step_div;
        logic load_out;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic key_end;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/djbhp_if.sv -----
interface key_if
    import djbhp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] key_char;

    modport source (output valid, output key_char, input ready);
    modport sink   (input valid, input key_char, output ready);
endinterface

interface part_if
    import djbhp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PART_W-1:0] partition_index;

    modport source (output valid, output partition_index, input ready);
    modport sink   (input valid, input partition_index, output ready);
endinterface

interface cfg_if
    import djbhp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PART_W-1:0] partition_count;

    modport source (output valid, output partition_count, input ready);
    modport sink   (input valid, input partition_count, output ready);
endinterface

// ----- hw/rtl/djbhp_ctrl.sv -----
module djbhp_ctrl
    import djbhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    div_state_t            state_reg;
    div_state_t            state_next;
    logic [STEP_CNT_W-1:0] count_reg;
    logic [STEP_CNT_W-1:0] count_next;

    // advance state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // key characters stream freely; a terminator waits for an idle divider
    always_comb
    begin
        key_ready     = !status.key_end || (state_reg == DIV_IDLE);
        cmd.take_char = key_valid && key_ready;
        cmd.start_div = cmd.take_char && status.key_end;
        cmd.step_div  = 1'b0;
        cmd.load_out  = 1'b0;
        state_next    = state_reg;
        count_next    = count_reg;

        case (state_reg)
            DIV_IDLE:
            begin
                if (cmd.start_div)
                begin
                    state_next = DIV_RUN;
                    count_next = '0;
                end
            end
            DIV_RUN:
            begin
                cmd.step_div = 1'b1;
                if (count_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = DIV_DONE;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            DIV_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/djbhp_dp.sv -----
module djbhp_dp
    import djbhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] key_char,
    input  logic              cfg_we,
    input  logic [PART_W-1:0] cfg_count,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [PART_W-1:0] partition_index,
    input  dp_cmd_t           cmd,
    output dp_status_t        status
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] dvd_reg;
    logic [PART_W-1:0] rem_reg;
    logic [PART_W-1:0] rem_next;
    logic [PART_W-1:0] div_reg;
    logic [PART_W-1:0] out_reg;
    logic              out_valid_reg;
    logic [PART_W:0]   trial;
    logic [PART_W:0]   diff;
    logic [HASH_W-1:0] char_ext;

    assign status.key_end  = (key_char == KEY_END);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign partition_index = out_reg;

    // hash*33 plus the sign-extended character
    always_comb
    begin
        char_ext  = {{(HASH_W-CHAR_W){key_char[CHAR_W-1]}}, key_char};
        hash_next = (hash_reg << 5) + hash_reg + char_ext;
    end

    // one restoring division step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[HASH_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (diff[PART_W])
        begin
            rem_next = trial[PART_W-1:0];
        end
        else
        begin
            rem_next = diff[PART_W-1:0];
        end
    end

    // hold running hash and partition count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_SEED;
            div_reg  <= PART_MIN;
        end
        else
        begin
            if (cmd.take_char)
            begin
                hash_reg <= status.key_end ? HASH_SEED : hash_next;
            end
            if (cfg_we)
            begin
                div_reg <= (cfg_count == '0) ? PART_MIN : cfg_count;
            end
        end
    end

    // divider registers: load the finished hash, then step once per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            dvd_reg <= hash_reg;
            rem_reg <= '0;
        end
        else if (cmd.step_div)
        begin
            dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- hw/rtl/djb2_hash_partitioner.sv -----
// djb2 key partitioner. Key bytes arrive on key_in, one per beat; each
// nonzero byte folds into a 64-bit hash (hash*33 + signed byte, seed 5381)
// as it is taken, so characters stream at one beat per clock. A zero
// byte closes the key: the hash is handed to a bit-serial restoring divider
// and the accumulator restarts at 5381, so the next key's characters keep
// flowing. The divider steps through every hash bit, then the remainder
// moves into the output register, and part_out goes valid with hash mod
// partition_count. A further terminator is held off until the divider is
// idle again, which happens as the remainder moves into the output
// register, so a new key cannot close before the last key's remainder is
// out of the divider. A stalled part_out keeps the remainder in the
// divider and holds off the next terminator longer.
// partition_count (reset 1; a write of 0 is taken as 1) may be written on
// cfg only while no key is in flight.
module djb2_hash_partitioner
    import djbhp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    key_if.sink    key_in,
    part_if.source part_out,
    cfg_if.sink    cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    djbhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_in.valid),
        .key_ready (key_in.ready),
        .status    (status),
        .cmd       (cmd)
    );

    djbhp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .key_char        (key_in.key_char),
        .cfg_we          (cfg.valid),
        .cfg_count       (cfg.partition_count),
        .out_ready       (part_out.ready),
        .out_valid       (part_out.valid),
        .partition_index (part_out.partition_index),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
